>>> design/ypd_pkg.sv
// Package for the YMODEM packet deframer.
// Holds the framing byte codes, the phase and status types and the result record.
// No dependencies.
`timescale 1ns / 1ps

package ypd_pkg;

    // Framing bytes of the protocol.
    localparam logic [7:0] BYTE_SOH     = 8'h01;
    localparam logic [7:0] BYTE_STX     = 8'h02;
    localparam logic [7:0] BYTE_EOT     = 8'h04;
    localparam logic [7:0] BYTE_CAN     = 8'h18;
    localparam logic [7:0] BYTE_ABORT_U = 8'h41;
    localparam logic [7:0] BYTE_ABORT_L = 8'h61;
    localparam logic [7:0] BYTE_ONES    = 8'hFF;

    // CRC-16/XMODEM generator polynomial.
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Index of the last data byte for each packet size.
    localparam logic [9:0] LAST_SMALL = 10'd127;
    localparam logic [9:0] LAST_LARGE = 10'd1023;

    // Length codes reported in a verdict.
    localparam logic [10:0] LEN_NONE   = 11'd0;
    localparam logic [10:0] LEN_CANCEL = 11'd2;
    localparam logic [10:0] LEN_SMALL  = 11'd128;
    localparam logic [10:0] LEN_LARGE  = 11'd1024;

    // Input kind and output item type codes.
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;
    localparam logic ITEM_DATA    = 1'b0;
    localparam logic ITEM_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_CA   = 3'd1,
        PH_NUM  = 3'd2,
        PH_CNUM = 3'd3,
        PH_DATA = 3'd4,
        PH_CRCH = 3'd5,
        PH_CRCL = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ERROR   = 2'd1,
        ST_ABORT   = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    // One result item as it travels to the output buffer.
    typedef struct packed {
        logic        item_type;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [10:0] pkt_len;
        logic [7:0]  block_number;
        logic        is_last;
    } ypd_result_t;

endpackage

>>> design/ypd_crc16.sv
// One-byte update step of CRC-16/XMODEM, purely combinational.
// Depends on ypd_pkg for the polynomial.
`timescale 1ns / 1ps

module ypd_crc16 (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);
    import ypd_pkg::*;

    // Eight shift steps, MSB first, no reflection.
    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

>>> design/ypd_core.sv
// Packet state machine and datapath of the deframer.
// Depends on ypd_pkg and ypd_crc16; emits at most one result per accepted transaction.
`timescale 1ns / 1ps

module ypd_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                kind,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output ypd_pkg::ypd_result_t res
);
    import ypd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        large_reg, large_next;
    logic [9:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  cseq_reg, cseq_next;
    logic [7:0]  trail_reg, trail_next;

    logic [15:0] crc_step;
    logic        timeout;
    logic        is_data_phase;
    logic [9:0]  last_index;

    ypd_crc16 u_crc (
        .crc_in  (crc_reg),
        .data    (rx_byte),
        .crc_out (crc_step)
    );

    assign timeout    = (kind == KIND_TIMEOUT);
    assign last_index = large_reg ? LAST_LARGE : LAST_SMALL;
    assign is_data_phase = (phase_reg == PH_NUM) || (phase_reg == PH_CNUM)
                        || (phase_reg == PH_DATA) || (phase_reg == PH_CRCH)
                        || (phase_reg == PH_CRCL);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (is_data_phase && timeout)
            begin
                phase_next = PH_IDLE;
            end
            else
            begin
                case (phase_reg)
                    PH_CA:   phase_next = PH_IDLE;
                    PH_NUM:  phase_next = PH_CNUM;
                    PH_CNUM: phase_next = PH_DATA;
                    PH_DATA:
                    begin
                        if (count_reg >= last_index)
                        begin
                            phase_next = PH_CRCH;
                        end
                    end
                    PH_CRCH: phase_next = PH_CRCL;
                    PH_CRCL: phase_next = PH_IDLE;
                    default:
                    begin
                        // Idle, and the unused code that behaves as idle.
                        if (timeout)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (rx_byte == BYTE_SOH || rx_byte == BYTE_STX)
                        begin
                            phase_next = PH_NUM;
                        end
                        else if (rx_byte == BYTE_CAN)
                        begin
                            phase_next = PH_CA;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    // Result item and packet datapath.
    always_comb
    begin
        large_next = large_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        seq_next   = seq_reg;
        cseq_next  = cseq_reg;
        trail_next = trail_reg;
        res_valid  = 1'b0;
        res        = '{item_type: ITEM_VERDICT, payload_byte: 8'h00, status: ST_OK,
                       pkt_len: LEN_NONE, block_number: 8'h00, is_last: 1'b1};
        if (accept)
        begin
            if (is_data_phase && timeout)
            begin
                res_valid        = 1'b1;
                res.status       = ST_TIMEOUT;
                res.block_number = seq_reg;
            end
            else
            begin
                case (phase_reg)
                    PH_CA:
                    begin
                        res_valid = 1'b1;
                        if (!timeout && rx_byte == BYTE_CAN)
                        begin
                            res.pkt_len = LEN_CANCEL;
                        end
                        else
                        begin
                            res.status = ST_ERROR;
                        end
                    end
                    PH_NUM:  seq_next  = rx_byte;
                    PH_CNUM: cseq_next = rx_byte;
                    PH_DATA:
                    begin
                        crc_next = crc_step;
                        if (count_reg < last_index)
                        begin
                            count_next = count_reg + 10'd1;
                        end
                        res_valid = 1'b1;
                        res       = '{item_type: ITEM_DATA, payload_byte: rx_byte,
                                      status: ST_OK, pkt_len: LEN_NONE,
                                      block_number: 8'h00, is_last: 1'b0};
                    end
                    PH_CRCH: trail_next = rx_byte;
                    PH_CRCL:
                    begin
                        res_valid        = 1'b1;
                        res.block_number = seq_reg;
                        if (seq_reg != (cseq_reg ^ BYTE_ONES)
                            || {trail_reg, rx_byte} != crc_reg)
                        begin
                            res.status = ST_ERROR;
                        end
                        else
                        begin
                            res.pkt_len = large_reg ? LEN_LARGE : LEN_SMALL;
                        end
                    end
                    default:
                    begin
                        if (timeout)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_TIMEOUT;
                        end
                        else if (rx_byte == BYTE_SOH || rx_byte == BYTE_STX)
                        begin
                            // Start of a data packet clears the packet fields.
                            large_next = (rx_byte == BYTE_STX);
                            count_next = 10'd0;
                            crc_next   = 16'h0000;
                            seq_next   = 8'h00;
                            cseq_next  = 8'h00;
                            trail_next = 8'h00;
                        end
                        else if (rx_byte == BYTE_CAN)
                        begin
                            res_valid = 1'b0;
                        end
                        else if (rx_byte == BYTE_EOT)
                        begin
                            res_valid = 1'b1;
                        end
                        else if (rx_byte == BYTE_ABORT_U || rx_byte == BYTE_ABORT_L)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_ABORT;
                        end
                        else
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_ERROR;
                        end
                    end
                endcase
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            large_reg <= 1'b0;
            count_reg <= 10'd0;
            crc_reg   <= 16'h0000;
            seq_reg   <= 8'h00;
            cseq_reg  <= 8'h00;
            trail_reg <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            large_reg <= large_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
            seq_reg   <= seq_next;
            cseq_reg  <= cseq_next;
            trail_reg <= trail_next;
        end
    end

endmodule

>>> design/ypd_out_buf.sv
// Output register with a skid stage for result items.
// Depends on ypd_pkg for the result record; ready toward the core is registered.
`timescale 1ns / 1ps

module ypd_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ypd_pkg::ypd_result_t push_data,
    output logic                 push_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ypd_pkg::ypd_result_t out_data
);
    import ypd_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    ypd_result_t out_data_reg, out_data_next;
    ypd_result_t skid_data_reg, skid_data_next;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // Fill the output register first; park a result in the skid slot on a stall.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

>>> design/ymodem_packet_deframer.sv
// Top level of the YMODEM packet deframer: stream ports, core and output buffer.
// Depends on ypd_pkg, ypd_core and ypd_out_buf.
//
//   Channel   Direction  tdata                          tuser      tlast
//   s_axis    in         rx_byte                        kind       -
//   m_axis    out        payload, status, len, block    item_type  is_last
//
// One transaction is accepted per cycle while s_tready is high; its result, if
// any, is registered in the output buffer; CRC and phase logic are combinational.
// Reset clears the phase and all packet fields to idle and zero.
// A stall on m_axis fills the skid slot; s_tready then drops until it drains.
`timescale 1ns / 1ps

module ymodem_packet_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] payload_byte, [9:8] status,
                                   // [20:10] pkt_len, [28:21] block_number
    output logic        m_tuser,   // [0] item_type
    output logic        m_tlast    // is_last
);
    import ypd_pkg::*;

    logic        accept;
    logic        res_valid;
    ypd_result_t res;
    ypd_result_t out_res;

    assign accept = s_tvalid && s_tready;

    ypd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (s_tuser),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    ypd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    // Pack the result fields onto the master side.
    assign m_tdata = {3'b000, out_res.block_number, out_res.pkt_len,
                      out_res.status, out_res.payload_byte};
    assign m_tuser = out_res.item_type;
    assign m_tlast = out_res.is_last;

endmodule

>>> design/ypd_checker.sv
// Port-level checker for the YMODEM packet deframer, bound to the top level.
// Depends only on the top-level port names.
`timescale 1ns / 1ps

module ypd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
        && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // Verdicts close a packet and data items never do.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == m_tuser))
        else $error("tlast does not match item type");

    // Data items carry only the payload byte.
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[31:8] == 24'h000000))
        else $error("data item has verdict fields set");

    // A nonzero length is only reported with an ok status.
    a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && (m_tdata[20:10] != 11'd0) |-> (m_tdata[9:8] == 2'd0))
        else $error("length reported on a failed verdict");

endmodule

bind ymodem_packet_deframer ypd_checker u_ypd_checker (.*);
